@@ hdl/dlgr_pkg.sv @@
package dlgr_pkg;

  localparam int LABEL_W  = 16;
  localparam int ZOOM_W   = 4;
  localparam int ROW_W    = 6;
  localparam int COL_W    = 8;
  localparam int OWID_W   = 8;
  localparam int OHGT_W   = 6;
  localparam int DIG_N    = 5;
  localparam int BCD_W    = 4 * DIG_N;
  localparam int CNT_W    = $clog2(LABEL_W + 1);
  localparam int RECIP_SH = 12;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LABEL_VALUE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM_FACTOR = 2'd1;

  localparam logic [LABEL_W-1:0] LABEL_RESET = 16'd0;
  localparam logic [ZOOM_W-1:0]  ZOOM_RESET  = 4'd3;

  typedef logic [3:0] digit_t;

  // ceil(2^RECIP_SH / z), exact quotient for dividends below 256 and z up to 16
  function automatic logic [RECIP_W-1:0] recip(input logic [4:0] z);
    logic [RECIP_W-1:0] m;
    case (z)
      5'd1:    m = 13'd4096;
      5'd2:    m = 13'd2048;
      5'd3:    m = 13'd1366;
      5'd4:    m = 13'd1024;
      5'd5:    m = 13'd820;
      5'd6:    m = 13'd683;
      5'd7:    m = 13'd586;
      5'd8:    m = 13'd512;
      5'd9:    m = 13'd456;
      5'd10:   m = 13'd410;
      5'd11:   m = 13'd373;
      5'd12:   m = 13'd342;
      5'd13:   m = 13'd316;
      5'd14:   m = 13'd293;
      5'd15:   m = 13'd274;
      5'd16:   m = 13'd256;
      default: m = 13'd4096;
    endcase
    return m;
  endfunction

  // 3x5 font, bit 2 is the leftmost column
  function automatic logic [2:0] glyph_row(input digit_t d, input logic [2:0] r);
    logic [14:0] g;
    logic [2:0] row;
    case (d)
      4'd0:    g = {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
      4'd1:    g = {3'd6, 3'd2, 3'd2, 3'd2, 3'd7};
      4'd2:    g = {3'd7, 3'd1, 3'd7, 3'd4, 3'd7};
      4'd3:    g = {3'd7, 3'd1, 3'd3, 3'd1, 3'd7};
      4'd4:    g = {3'd5, 3'd5, 3'd7, 3'd1, 3'd1};
      4'd5:    g = {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
      4'd6:    g = {3'd7, 3'd4, 3'd7, 3'd5, 3'd7};
      4'd7:    g = {3'd7, 3'd1, 3'd3, 3'd1, 3'd1};
      4'd8:    g = {3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
      4'd9:    g = {3'd7, 3'd5, 3'd7, 3'd1, 3'd7};
      default: g = 15'd0;
    endcase
    case (r)
      3'd0:    row = g[14:12];
      3'd1:    row = g[11:9];
      3'd2:    row = g[8:6];
      3'd3:    row = g[5:3];
      3'd4:    row = g[2:0];
      default: row = 3'd0;
    endcase
    return row;
  endfunction

endpackage

@@ hdl/decimal_label_glyph_renderer.sv @@
// decimal_label_glyph_renderer: draws label_value as a zoomed 3x5 digit label.
// in_ channel: one pixel query per item, tdata = {pixel_col, pixel_row}.
// out_ channel: one result per query, tdata = {label_height, label_width,
//   in_bounds, ink}; ink is 0 outside the label and in spacer columns.
// cfg_ channel: cfg_index 0 writes label_value, 1 writes zoom_factor; other
//   indexes are taken and ignored. cfg_ready is always high.
// Throughput: one item per cycle while the output is not stalled and no decimal
//   conversion is running. Pipeline: 3 register stages (multiply by zoom reciprocal,
//   digit select, font lookup), with out_tvalid registered in the last.
// After reset and after every configuration write the label value is
//   converted to decimal by a shift-and-add-3 loop, one bit per cycle (a new write
//   restarts it), during which in_tready is low. Label width, height and the zoom
//   reciprocal are settled in the last cycle of that pass.
// Reset gives label_value 0 and zoom_factor 3 and empties the pipeline.
// When out_tready is low with a result waiting, the pipeline holds and
//   in_tready drops, so no item is lost or repeated; items wait in their stages.
// Zoom 0 acts as 1, zoom above MAX_ZOOM as MAX_ZOOM; only the low
//   MAX_DIGITS digits are drawn.
module decimal_label_glyph_renderer #(
  parameter int MAX_DIGITS = 5,
  parameter int MAX_ZOOM   = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [15:0]                       in_tdata,   // pixel_row[5:0], pixel_col[13:6], zero pad
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [15:0]                       out_tdata,  // ink, in_bounds, label_width, label_height
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dlgr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dlgr_pkg::LABEL_W-1:0]      cfg_data
);

  localparam int SHOW    = (MAX_DIGITS < dlgr_pkg::DIG_N) ? MAX_DIGITS : dlgr_pkg::DIG_N;
  localparam int NW      = $clog2(SHOW + 1);
  localparam int ZW      = $clog2(MAX_ZOOM + 1);
  localparam int WID_MAX = (4 * SHOW - 1) * MAX_ZOOM;
  localparam int WID_W   = $clog2(WID_MAX + 1);
  localparam int WP_W    = NW + 2 + ZW;
  localparam int HGT_W   = $clog2(5 * MAX_ZOOM + 1);
  localparam int CW      = (WID_W > dlgr_pkg::COL_W) ? WID_W : dlgr_pkg::COL_W;
  localparam int RW      = (HGT_W > dlgr_pkg::ROW_W) ? HGT_W : dlgr_pkg::ROW_W;
  localparam int SH_W    = dlgr_pkg::BCD_W + dlgr_pkg::LABEL_W;
  localparam int RP_W    = dlgr_pkg::ROW_W + dlgr_pkg::RECIP_W;
  localparam int CP_W    = dlgr_pkg::COL_W + dlgr_pkg::RECIP_W;

  // configuration registers and decimal conversion
  logic [dlgr_pkg::LABEL_W-1:0] label_r;
  logic [dlgr_pkg::ZOOM_W-1:0]  zoom_r;
  logic                         load_r, busy_r;
  logic [dlgr_pkg::CNT_W-1:0]   cnt_r;
  logic [SH_W-1:0]              sh_r, sh_adj;
  dlgr_pkg::digit_t             dig_r [dlgr_pkg::DIG_N];
  logic [NW-1:0]                n_r, n_nxt;
  logic [WID_W-1:0]             wid_r, wid_nxt;
  logic [HGT_W-1:0]             hgt_r, hgt_nxt;
  logic [dlgr_pkg::RECIP_W-1:0] recip_r;
  logic [ZW-1:0]                zeff;

  assign cfg_ready = 1'b1;

  always_comb begin
    sh_adj = sh_r;
    for (int i = 0; i < dlgr_pkg::DIG_N; i++) begin
      if (sh_r[dlgr_pkg::LABEL_W + 4*i +: 4] >= 4'd5) begin
        sh_adj[dlgr_pkg::LABEL_W + 4*i +: 4] = sh_r[dlgr_pkg::LABEL_W + 4*i +: 4] + 4'd3;
      end
    end
  end

  always_comb begin
    if (zoom_r == '0) begin
      zeff = ZW'(1);
    end else if (5'(zoom_r) > 5'(MAX_ZOOM)) begin
      zeff = ZW'(MAX_ZOOM);
    end else begin
      zeff = ZW'(zoom_r);
    end
    n_nxt = NW'(1);
    for (int i = 1; i < dlgr_pkg::DIG_N; i++) begin
      if (sh_r[dlgr_pkg::LABEL_W + 4*i +: 4] != 4'd0) begin
        n_nxt = NW'((i + 1 < SHOW) ? i + 1 : SHOW);
      end
    end
    wid_nxt = WID_W'((WP_W'({n_nxt, 2'b00}) - WP_W'(1)) * WP_W'(zeff));
    hgt_nxt = HGT_W'(HGT_W'(zeff) * HGT_W'(5));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      label_r <= dlgr_pkg::LABEL_RESET;
      zoom_r  <= dlgr_pkg::ZOOM_RESET;
      load_r  <= 1'b1;
      busy_r  <= 1'b1;
      cnt_r   <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == dlgr_pkg::REG_LABEL_VALUE) begin
        label_r <= cfg_data;
      end else if (cfg_index == dlgr_pkg::REG_ZOOM_FACTOR) begin
        zoom_r <= cfg_data[dlgr_pkg::ZOOM_W-1:0];
      end
      load_r <= 1'b1;
      busy_r <= 1'b1;
    end else if (load_r) begin
      load_r <= 1'b0;
      cnt_r  <= dlgr_pkg::CNT_W'(dlgr_pkg::LABEL_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end else if (busy_r) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_r) begin
      sh_r <= {{dlgr_pkg::BCD_W{1'b0}}, label_r};
    end else if (cnt_r != '0) begin
      sh_r <= {sh_adj[SH_W-2:0], 1'b0};
    end
    if (busy_r && !load_r && cnt_r == '0) begin
      for (int i = 0; i < dlgr_pkg::DIG_N; i++) begin
        dig_r[i] <= sh_r[dlgr_pkg::LABEL_W + 4*i +: 4];
      end
      n_r     <= n_nxt;
      wid_r   <= wid_nxt;
      hgt_r   <= hgt_nxt;
      recip_r <= dlgr_pkg::recip(5'(zeff));
    end
  end

  // pixel pipeline
  logic advance;
  logic v1_r, v2_r, out_valid_r;
  logic [RP_W-1:0] rprod_r;
  logic [CP_W-1:0] cprod_r;
  logic            inb1_r, inb2_r, inb3_r;
  logic [2:0]      r2_r;
  logic [1:0]      sub2_r;
  logic            dv2_r;
  dlgr_pkg::digit_t dig2_r;
  logic            ink_r;

  logic [dlgr_pkg::ROW_W-1:0] in_row, rq;
  logic [dlgr_pkg::COL_W-1:0] in_col, cq;
  logic [5:0]                 k, idx;
  logic                       kv;
  logic [2:0]                 grow;
  logic                       gbit;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance && !busy_r;
  assign in_row    = in_tdata[dlgr_pkg::ROW_W-1:0];
  assign in_col    = in_tdata[dlgr_pkg::ROW_W +: dlgr_pkg::COL_W];

  assign rq  = rprod_r[dlgr_pkg::RECIP_SH +: dlgr_pkg::ROW_W];
  assign cq  = cprod_r[dlgr_pkg::RECIP_SH +: dlgr_pkg::COL_W];
  assign k   = cq[7:2];
  assign kv  = k < 6'(n_r);
  assign idx = 6'(n_r) - 6'd1 - k;

  always_comb begin
    grow = dlgr_pkg::glyph_row(dig2_r, r2_r);
    case (sub2_r)
      2'd0:    gbit = grow[2];
      2'd1:    gbit = grow[1];
      2'd2:    gbit = grow[0];
      default: gbit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      v1_r        <= in_tvalid && in_tready;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rprod_r <= RP_W'(in_row) * RP_W'(recip_r);
      cprod_r <= CP_W'(in_col) * CP_W'(recip_r);
      inb1_r  <= (RW'(in_row) < RW'(hgt_r)) && (CW'(in_col) < CW'(wid_r));
      r2_r    <= rq[2:0];
      sub2_r  <= cq[1:0];
      dv2_r   <= kv;
      dig2_r  <= kv ? dig_r[idx[2:0]] : dlgr_pkg::digit_t'(0);
      inb2_r  <= inb1_r;
      ink_r   <= inb2_r && dv2_r && gbit;
      inb3_r  <= inb2_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(dlgr_pkg::OHGT_W)'(hgt_r), (dlgr_pkg::OWID_W)'(wid_r), inb3_r, ink_r};

endmodule

@@ verif/decimal_label_glyph_renderer_checker.sv @@
module decimal_label_glyph_renderer_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [15:0]                    in_tdata,   // pixel_row, pixel_col, zero pad
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [15:0]                    out_tdata,  // ink, in_bounds, label_width, label_height
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [dlgr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dlgr_pkg::LABEL_W-1:0]   cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCALE_MAX  = 8;
  localparam int DIGITS_MAX = 5;

  typedef struct packed {
    logic [5:0] height;
    logic [7:0] width;
    logic       in_bounds;
    logic       ink;
  } pixel_result_t;

  // digit, row top to bottom, bit 2 is the leftmost column
  localparam logic [0:9][0:4][2:0] GLYPH_FONT = {
    3'd7, 3'd5, 3'd5, 3'd5, 3'd7,
    3'd6, 3'd2, 3'd2, 3'd2, 3'd7,
    3'd7, 3'd1, 3'd7, 3'd4, 3'd7,
    3'd7, 3'd1, 3'd3, 3'd1, 3'd7,
    3'd5, 3'd5, 3'd7, 3'd1, 3'd1,
    3'd7, 3'd4, 3'd7, 3'd1, 3'd7,
    3'd7, 3'd4, 3'd7, 3'd5, 3'd7,
    3'd7, 3'd1, 3'd3, 3'd1, 3'd1,
    3'd7, 3'd5, 3'd7, 3'd5, 3'd7,
    3'd7, 3'd5, 3'd7, 3'd1, 3'd7
  };

  logic [15:0]   label_q;
  logic [3:0]    zoom_q;
  pixel_result_t expected_pixels[$];
  int            fails;
  int            results;

  function automatic pixel_result_t render_pixel(input logic [5:0] row, input logic [7:0] col);
    pixel_result_t res;
    int z;
    int n;
    int v;
    int w;
    int h;
    int r;
    int c;
    int k;
    int sub;
    int digs [0:4];
    z = zoom_q;
    if (z == 0) z = 1;
    if (z > SCALE_MAX) z = SCALE_MAX;
    v = label_q;
    n = 0;
    if (v == 0) begin
      digs[0] = 0;
      n = 1;
    end else begin
      while (v > 0 && n < DIGITS_MAX) begin
        digs[n] = v % 10;
        v = v / 10;
        n++;
      end
    end
    w = (4 * n - 1) * z;
    h = 5 * z;
    res.width = w[7:0];
    res.height = h[5:0];
    res.in_bounds = (row < h) && (col < w);
    res.ink = 1'b0;
    if (res.in_bounds) begin
      r = row / z;
      c = col / z;
      k = c / 4;
      sub = c % 4;
      // spacer column stays white
      if (sub < 3 && k < n && r < 5) res.ink = GLYPH_FONT[digs[n-1-k]][r][2-sub];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fails < 100) $display("mismatch at %0t: %s", $realtime, msg);
    fails++;
  endtask

  always @(posedge clk) begin : watch
    pixel_result_t got;
    pixel_result_t want;
    if (!rst_n) begin
      label_q = dlgr_pkg::LABEL_RESET;
      zoom_q = dlgr_pkg::ZOOM_RESET;
      expected_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == dlgr_pkg::REG_LABEL_VALUE) label_q = cfg_data;
        else if (cfg_index == dlgr_pkg::REG_ZOOM_FACTOR) zoom_q = cfg_data[3:0];
      end
      if (in_tvalid && in_tready)
        expected_pixels.push_back(render_pixel(in_tdata[5:0], in_tdata[13:6]));
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("result %h with no query waiting", out_tdata));
        end else begin
          want = expected_pixels.pop_front();
          results++;
          if (got.ink !== want.ink)
            report_mismatch($sformatf("result %0d ink got %b want %b",
                                      results, got.ink, want.ink));
          if (got.in_bounds !== want.in_bounds)
            report_mismatch($sformatf("result %0d in_bounds got %b want %b",
                                      results, got.in_bounds, want.in_bounds));
          if (got.width !== want.width)
            report_mismatch($sformatf("result %0d label_width got %0d want %0d",
                                      results, got.width, want.width));
          if (got.height !== want.height)
            report_mismatch($sformatf("result %0d label_height got %0d want %0d",
                                      results, got.height, want.height));
        end
      end
    end
    fail_count <= fails;
    pending <= expected_pixels.size();
    checked <= results;
  end

endmodule

@@ verif/decimal_label_glyph_renderer_tb.sv @@
module decimal_label_glyph_renderer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [dlgr_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [dlgr_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES    = 12;
  localparam int PHASE_ITEMS      = 125;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [15:0]                    in_tdata;   // pixel_row, pixel_col, zero pad
  logic                           out_tvalid;
  logic                           out_tready;
  logic [15:0]                    out_tdata;  // ink, in_bounds, label_width, label_height
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [dlgr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [dlgr_pkg::LABEL_W-1:0]   cfg_data;

  int fail_count;
  int pending;
  int checked;
  int sent;
  int settings;
  int cur_w;
  int cur_h;
  bit gaps_on;
  bit stalls_on;
  bit long_hold_req;

  decimal_label_glyph_renderer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  decimal_label_glyph_renderer_checker pixel_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #10_000_000;
    $display("timeout with %0d results still pending", pending);
    $display("Simulation FAILED");
    $finish;
  end

  // receiver: random stall bursts, one long hold on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
        long_hold_req = 1'b0;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_pixel(input logic [5:0] row, input logic [7:0] col);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 11)) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, col, row};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic wait_drained;
    @(negedge clk);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dlgr_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_label(input logic [15:0] value, input logic [3:0] zoom);
    logic [15:0] zoom_word;
    int z;
    int n;
    int v;
    z = (zoom == 0) ? 1 : (zoom > 8) ? 8 : zoom;
    n = 1;
    for (v = value; v >= 10; v = v / 10) n++;
    cur_w = (4 * n - 1) * z;
    cur_h = 5 * z;
    zoom_word = 16'($urandom);
    zoom_word[3:0] = zoom;
    wait_drained();
    if ($urandom_range(0, 1) == 0) begin
      write_reg(dlgr_pkg::REG_LABEL_VALUE, value);
      write_reg(dlgr_pkg::REG_ZOOM_FACTOR, zoom_word);
    end else begin
      write_reg(dlgr_pkg::REG_ZOOM_FACTOR, zoom_word);
      write_reg(dlgr_pkg::REG_LABEL_VALUE, value);
    end
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
    settings++;
  endtask

  task automatic run_random(input int count);
    repeat (count) begin
      if ($urandom_range(0, 7) != 0)
        send_pixel(6'($urandom_range(0, cur_h - 1)), 8'($urandom_range(0, cur_w - 1)));
      else
        send_pixel(6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    int p;
    int n;
    int lo;
    int hi;
    logic [15:0] value;
    logic [3:0] zoom;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = dlgr_pkg::REG_LABEL_VALUE;
    cfg_data = '0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    long_hold_req = 1'b0;
    sent = 0;
    settings = 1;
    cur_w = 9;
    cur_h = 15;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset label: single zero at zoom 3
    send_pixel(6'd0, 8'd0);
    send_pixel(6'd14, 8'd8);
    send_pixel(6'd15, 8'd9);
    send_pixel(6'd63, 8'd255);

    // widest and tallest label
    set_label(16'd65535, 4'd8);
    send_pixel(6'd0, 8'd0);
    send_pixel(6'd39, 8'd151);
    send_pixel(6'd40, 8'd151);
    send_pixel(6'd39, 8'd152);
    send_pixel(6'd16, 8'd24);
    send_pixel(6'd63, 8'd255);

    // zoom of zero acts as one
    set_label(16'd12345, 4'd0);
    send_pixel(6'd0, 8'd0);
    send_pixel(6'd4, 8'd18);
    send_pixel(6'd5, 8'd18);
    send_pixel(6'd4, 8'd19);
    send_pixel(6'd2, 8'd3);

    // zoom above the maximum saturates
    set_label(16'd9, 4'd15);
    send_pixel(6'd0, 8'd0);
    send_pixel(6'd39, 8'd23);
    send_pixel(6'd10, 8'd12);
    wait_drained();
    write_reg(REG_SPARE_A, 16'hffff);
    write_reg(REG_SPARE_B, 16'h0001);
    send_pixel(6'd20, 8'd4);

    for (p = 0; p < RANDOM_PHASES; p++) begin
      n = $urandom_range(1, 5);
      lo = (n == 1) ? 0 : 10 ** (n - 1);
      hi = (10 ** n) - 1;
      if (hi > 65535) hi = 65535;
      value = 16'($urandom_range(lo, hi));
      zoom = 4'($urandom_range(0, 15));
      case (p)
        0: zoom = 4'd1;
        1: zoom = 4'd8;
        2: zoom = 4'd0;
        3: zoom = 4'd15;
        4: value = 16'd65535;
        5: value = 16'd0;
        default: ;
      endcase
      if (p >= RANDOM_PHASES - 2) begin
        gaps_on = 1'b0;
        stalls_on = 1'b0;
      end
      set_label(value, zoom);
      if (p == 3) long_hold_req = 1'b1;
      run_random(PHASE_ITEMS);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("covered %0d pixel items across %0d label settings, %0d results checked",
             sent, settings, checked);
    $display("zooms 0, 1, 8 and 15, labels of one to five digits, a %0d-cycle output hold",
             LONG_HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/dlgr_pkg.sv
hdl/decimal_label_glyph_renderer.sv
verif/decimal_label_glyph_renderer_checker.sv
verif/decimal_label_glyph_renderer_tb.sv
